FILE: sv/jsti_pkg.sv
`default_nettype none
package jsti_pkg;

    localparam int unsigned W_POS = 31;

    localparam logic [W_POS-1:0] MAX_OFFSET = 31'h7FFF_FFFF;
    localparam logic [W_POS-1:0] CAP_RESET  = 31'h7FFF_FFFF;

    // report status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ILLEGAL  = 3'd1;
    localparam logic [2:0] ST_UNTERM   = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_TOO_LONG = 3'd4;

    // input beat modes
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_END  = 1'b1;

    // result kinds
    localparam logic KIND_ENTRY  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // characters
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UPPER_E = 8'h45;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;
    localparam logic [7:0] CODE_PRIM  = 8'h70;

    typedef struct packed {
        logic             in_str;
        logic             after_bs;
        logic             in_prim;
        logic [W_POS-1:0] offset;
        logic [W_POS-1:0] count;
        logic [2:0]       err;
    } t_doc_state;

    typedef struct packed {
        logic             kind;
        logic [7:0]       entry_code;
        logic [W_POS-1:0] entry_position;
        logic [W_POS-1:0] entry_slot;
        logic [2:0]       status;
        logic [W_POS-1:0] entry_total;
    } t_result;

endpackage
`default_nettype wire

FILE: sv/jsti_in_if.sv
`default_nettype none
interface jsti_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data_byte;

    modport source (output valid, output mode, output data_byte, input ready);
    modport sink   (input valid, input mode, input data_byte, output ready);
endinterface
`default_nettype wire

FILE: sv/jsti_out_if.sv
`default_nettype none
interface jsti_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  entry_code;
    logic [30:0] entry_position;
    logic [30:0] entry_slot;
    logic [2:0]  status;
    logic [30:0] entry_total;

    modport source (output valid, output kind, output entry_code, output entry_position,
                    output entry_slot, output status, output entry_total, input ready);
    modport sink   (input valid, input kind, input entry_code, input entry_position,
                    input entry_slot, input status, input entry_total, output ready);
endinterface
`default_nettype wire

FILE: sv/jsti_step.sv
`default_nettype none
module jsti_step
    import jsti_pkg::*;
(
    input  wire t_doc_state       i_cur,
    input  wire                   i_mode,
    input  wire [7:0]             i_byte,
    input  wire [W_POS-1:0]       i_cap,
    output t_doc_state            o_nxt,
    output logic                  o_res_valid,
    output t_result               o_res
);

    logic       rec;
    logic [7:0] rec_code;
    logic [2:0] st;

    always_comb begin
        o_nxt       = i_cur;
        o_res_valid = 1'b0;
        o_res       = '0;
        rec         = 1'b0;
        rec_code    = i_byte;
        st          = i_cur.err;

        if (i_mode == MODE_END) begin
            if (st == ST_OK) begin
                if (i_cur.in_str || i_cur.after_bs) begin
                    st = ST_UNTERM;
                end else if (i_cur.count > i_cap) begin
                    st = ST_OVERFLOW;
                end
            end
            o_res_valid       = 1'b1;
            o_res.kind        = KIND_REPORT;
            o_res.status      = st;
            o_res.entry_total = i_cur.count;
            o_nxt             = '0;
        end else if (i_cur.err != ST_OK) begin
            // document already failed, byte dropped
        end else if (i_cur.offset == MAX_OFFSET) begin
            o_nxt.err = ST_TOO_LONG;
        end else begin
            if (i_cur.in_str) begin
                if (i_cur.after_bs) begin
                    o_nxt.after_bs = 1'b0;
                end else if (i_byte == CH_BSLASH) begin
                    o_nxt.after_bs = 1'b1;
                end else if (i_byte == CH_QUOTE) begin
                    o_nxt.in_str = 1'b0;
                end else if (i_byte < CH_SPACE) begin
                    o_nxt.err = ST_ILLEGAL;
                end
            end else if (i_byte == CH_QUOTE) begin
                o_nxt.in_prim = 1'b0;
                o_nxt.in_str  = 1'b1;
                rec           = 1'b1;
            end else if (i_byte inside {CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK,
                                        CH_COLON, CH_COMMA}) begin
                o_nxt.in_prim = 1'b0;
                rec           = 1'b1;
            end else if (i_byte inside {[CH_ZERO:CH_NINE], CH_MINUS, CH_LOWER_T,
                                        CH_LOWER_F, CH_LOWER_N}) begin
                if (!i_cur.in_prim) begin
                    o_nxt.in_prim = 1'b1;
                    rec           = 1'b1;
                    rec_code      = CODE_PRIM;
                end
            end else if (i_byte inside {CH_SPACE, CH_TAB, CH_LF, CH_CR}) begin
                o_nxt.in_prim = 1'b0;
            end else if (i_cur.in_prim &&
                         (i_byte inside {CH_DOT, CH_PLUS, CH_UPPER_E,
                                         [CH_LOWER_A:CH_LOWER_Z]})) begin
                // number or literal continues
            end else begin
                o_nxt.err = ST_ILLEGAL;
            end

            if (o_nxt.err == ST_OK) begin
                o_nxt.offset = W_POS'(i_cur.offset + 1'b1);
            end

            if (rec) begin
                o_nxt.count = W_POS'(i_cur.count + 1'b1);
                // slots past the tape are counted only
                if (i_cur.count < i_cap) begin
                    o_res_valid          = 1'b1;
                    o_res.kind           = KIND_ENTRY;
                    o_res.entry_code     = rec_code;
                    o_res.entry_position = i_cur.offset;
                    o_res.entry_slot     = i_cur.count;
                end
            end
        end
    end

endmodule
`default_nettype wire

FILE: sv/json_structural_tape_indexer.sv
// JSON structural tape indexer.
// i_in carries one beat per document byte (mode 0, data_byte) or an end
// beat (mode 1) that closes the document. o_out carries tape entries
// (kind 0: code, byte position, tape slot) and one report per end beat
// (kind 1: status and entry total); the per-document flags, offset, count
// and error are then cleared.
// i_cfg_we/i_cfg_wdata write the tape capacity; write only while idle.
// A beat taken from i_in lands in the input register; its result is
// computed from there and held in the output register. Throughput is
// one beat per cycle while the receiver does not stall: the whole
// classification and flag update is one combinational step between
// the two registers.
// Bytes that make no entry, and entries past the capacity, produce no beat.
// When the receiver stalls, the held result and the input register fill
// and i_in.ready drops; nothing is lost or repeated.
// Reset clears all document state, empties both registers and sets the
// capacity to 0x7FFFFFFF.
`default_nettype none
module json_structural_tape_indexer
    import jsti_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire [W_POS-1:0]  i_cfg_wdata,
    jsti_in_if.sink          i_in,
    jsti_out_if.source       o_out
);

    logic [W_POS-1:0] r_cap;
    t_doc_state       r_state;
    t_doc_state       n_state;
    logic             r_in_valid;
    logic             r_in_mode;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    t_result          r_out;
    t_result          res;
    logic             res_valid;
    logic             advance;
    logic             in_ready;

    assign advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign in_ready = !r_in_valid || advance;

    jsti_step u_step (
        .i_cur      (r_state),
        .i_mode     (r_in_mode),
        .i_byte     (r_in_byte),
        .i_cap      (r_cap),
        .o_nxt      (n_state),
        .o_res_valid(res_valid),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= '0;
            r_in_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_state <= n_state;
            end
            if (in_ready) begin
                r_in_valid <= i_in.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_in_mode <= i_in.mode;
            r_in_byte <= i_in.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || o_out.ready) begin
            r_out_valid <= advance && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign i_in.ready           = in_ready;
    assign o_out.valid          = r_out_valid;
    assign o_out.kind           = r_out.kind;
    assign o_out.entry_code     = r_out.entry_code;
    assign o_out.entry_position = r_out.entry_position;
    assign o_out.entry_slot     = r_out.entry_slot;
    assign o_out.status         = r_out.status;
    assign o_out.entry_total    = r_out.entry_total;

    // an end beat leaves a fresh document behind
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_mode == MODE_END) |=>
            (r_state.offset == '0 && r_state.count == '0 && r_state.err == ST_OK))
        else $error("document state not cleared after end beat");

    // a failed document no longer advances its offset
    a_err_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.err != ST_OK && !(advance && r_in_mode == MODE_END)) |=>
            $stable(r_state.offset))
        else $error("offset moved after error");

    // each entry consumes a byte, so the count never passes the offset
    a_count_le_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.count <= r_state.offset)
        else $error("entry count exceeds byte offset");

endmodule
`default_nettype wire
